// ----- rtl/owps_pkg.sv -----
// shared constants, codes and crc helpers of the one-wire paged scratchpad slave
`default_nettype none

package owps_pkg;

	// memory geometry
	localparam int PAGES     = 8;
	localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W    = PAGE_W + 3;
	localparam int MEM_BYTES = PAGES * 8;

	// nibble steps of one page crc
	localparam logic [4:0] CRC_STEPS = 5'd16;

	// input operations
	typedef enum logic [2:0] {
		OP_BUS_RESET  = 3'd0,
		OP_BUS_BYTE   = 3'd1,
		OP_HOST_WRITE = 3'd2,
		OP_HOST_READ  = 3'd3,
		OP_SET_TEMP   = 3'd4,
		OP_SET_VOLT   = 3'd5,
		OP_SET_CURR   = 3'd6
	} op_t;

	// result kinds
	localparam logic [1:0] KIND_BUS     = 2'd0;
	localparam logic [1:0] KIND_HOST    = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;
	localparam logic [1:0] KIND_RANGE   = 2'd3;

	// bus commands
	localparam logic [7:0] CMD_READ_SP  = 8'hBE;
	localparam logic [7:0] CMD_WRITE_SP = 8'h4E;
	localparam logic [7:0] CMD_COPY_SP  = 8'h48;
	localparam logic [7:0] CMD_RECALL   = 8'hB8;
	localparam logic [7:0] CMD_CONV_T   = 8'h44;
	localparam logic [7:0] CMD_CONV_V   = 8'hB4;

	// status byte after reset
	localparam logic [7:0] RESET_BYTE0 = 8'h03;

	// temperature clamp in 1/256 degree
	localparam logic signed [15:0] TEMP_MAX = 16'(125 * 256);
	localparam logic signed [15:0] TEMP_MIN = 16'(-55 * 256);

	// fixed byte positions of the setters in page 0
	localparam logic [ADDR_W-1:0] POS_TEMP_LO = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] POS_TEMP_HI = ADDR_W'(2);
	localparam logic [ADDR_W-1:0] POS_VOLT_LO = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] POS_VOLT_HI = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] POS_CURR_LO = ADDR_W'(5);
	localparam logic [ADDR_W-1:0] POS_CURR_HI = ADDR_W'(6);

	// four bits of the reflected crc-8 (poly 0x8c), lsb first
	function automatic logic [7:0] crc4(input logic [7:0] c, input logic [3:0] d);
		logic [7:0] r;
		logic       mix;
		r = c;
		for (int i = 0; i < 4; i++) begin
			mix = r[0] ^ d[i];
			r   = {1'b0, r[7:1]};
			if (mix) begin
				r = r ^ 8'h8C;
			end
		end
		return r;
	endfunction

	// crc of page 0 as it stands after reset
	function automatic logic [7:0] reset_crc0();
		logic [7:0] r;
		r = crc4(8'h00, RESET_BYTE0[3:0]);
		r = crc4(r, RESET_BYTE0[7:4]);
		for (int i = 0; i < 14; i++) begin
			r = crc4(r, 4'h0);
		end
		return r;
	endfunction

	localparam logic [7:0] RESET_CRC0 = reset_crc0();

endpackage

`default_nettype wire

// ----- rtl/one_wire_paged_scratchpad_slave.sv -----
// top level of the one-wire paged scratchpad slave: command decode, memory and crc sequencer
`default_nettype none

// Byte-level one-wire battery monitor slave. A request is taken when start is high and
// busy is low; results come out one per cycle on out_byte/out_kind/last with strobe high
// for exactly one cycle each, and cannot be held off. After reset the block runs a pass
// that clears the page memory and writes the status byte 0x03 to byte 0 (busy stays
// high). A valid read scratchpad page number keeps busy high while its nine results (the
// eight page bytes, then the page crc) follow the memory reads through the registered
// read data and the result registers. A host read keeps busy high while its read data
// is pending. In-range host writes, setters and the eighth write scratchpad byte end in
// a page crc run over the single memory read port, one nibble per cycle; when a host
// write has host_last set and the byte after it is still in memory, the page holding
// that byte gets its crc run as well, even when it is the same page.
module one_wire_paged_scratchpad_slave (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [2:0]  operation,
	input  wire logic        [7:0]  rx_byte,
	input  wire logic        [5:0]  address,
	input  wire logic               host_last,
	input  wire logic signed [15:0] temperature,
	input  wire logic        [9:0]  voltage,
	input  wire logic signed [10:0] current_value,
	output logic                    strobe,
	output logic             [7:0]  out_byte,
	output logic             [1:0]  out_kind,
	output logic                    last
);

	localparam int PAGE_W = owps_pkg::PAGE_W;
	localparam int ADDR_W = owps_pkg::ADDR_W;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WR2,
		S_PREAD,
		S_CRC
	} state_t;

	typedef enum logic [2:0] {
		P_IDLE,
		P_READ_PAGE,
		P_WRITE_PAGE,
		P_WRITE_DATA,
		P_RECALL,
		P_DONE
	} phase_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [PAGE_W-1:0]   sel_q;
	logic [2:0]          count_q;
	logic [ADDR_W-1:0]   init_q;
	logic [3:0]          idx_q;
	logic [4:0]          step_q;
	logic [7:0]          crc_acc_q;
	logic [PAGE_W-1:0]   crc_pg_q;
	logic                nxt_pend_q;
	logic [PAGE_W-1:0]   nxt_pg_q;
	logic [ADDR_W-1:0]   wr2_addr_q;
	logic [7:0]          wr2_data_q;
	logic [7:0]          page_check_q [owps_pkg::PAGES];

	// read tag: the registered read data becomes a result next cycle
	logic                pend_q;
	logic                pend_crc_q;
	logic [1:0]          pend_kind_q;
	logic                pend_last_q;

	logic                strobe_q;
	logic [7:0]          out_byte_q;
	logic [1:0]          out_kind_q;
	logic                last_q;

	// page memory
	logic [7:0]          mem [owps_pkg::MEM_BYTES];
	logic [7:0]          rd_data_q;

	logic                accept;
	logic                we;
	logic [ADDR_W-1:0]   wa;
	logic [7:0]          wd;
	logic                re;
	logic [ADDR_W-1:0]   ra;

	logic                addr_ok;
	logic [ADDR_W-1:0]   host_addr;
	logic [PAGE_W-1:0]   host_pg;
	logic [7:0]          nxt8;
	logic                nxt_ok;
	logic                rx_pg_ok;
	logic                wr_allowed;
	logic                cmd_known;

	logic signed [15:0]  t_cl;
	logic [7:0]          set_lo;
	logic [7:0]          set_hi;
	logic [ADDR_W-1:0]   set_pos_lo;
	logic [ADDR_W-1:0]   set_pos_hi;

	logic [3:0]          crc_k;
	logic [2:0]          crc_byte;
	logic [3:0]          crc_nib;
	logic [7:0]          crc_nx;

	assign busy     = (state_q != S_IDLE) || pend_q;
	assign accept   = start && !busy;
	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign out_kind = out_kind_q;
	assign last     = last_q;

	// address and page decode of the request
	assign addr_ok    = 8'(address) < 8'(owps_pkg::MEM_BYTES);
	assign host_addr  = ADDR_W'(address);
	assign host_pg    = PAGE_W'(address >> 3);
	assign nxt8       = (8'(address) + 8'd1) >> 3;
	assign nxt_ok     = nxt8 < 8'(owps_pkg::PAGES);
	assign rx_pg_ok   = rx_byte < 8'(owps_pkg::PAGES);
	assign wr_allowed = !((sel_q == '0) && (count_q != 3'd0) && (count_q != 3'd7));
	assign cmd_known  = (rx_byte == owps_pkg::CMD_READ_SP) ||
		(rx_byte == owps_pkg::CMD_WRITE_SP) || (rx_byte == owps_pkg::CMD_COPY_SP) ||
		(rx_byte == owps_pkg::CMD_RECALL) || (rx_byte == owps_pkg::CMD_CONV_T) ||
		(rx_byte == owps_pkg::CMD_CONV_V);

	// crc nibble datapath
	assign crc_k    = 4'(step_q - 5'd1);
	assign crc_byte = crc_k[3:1];
	assign crc_nib  = crc_k[0] ? rd_data_q[7:4] : rd_data_q[3:0];
	assign crc_nx   = owps_pkg::crc4(crc_acc_q, crc_nib);

	// setter byte pairs
	always_comb begin
		t_cl = temperature;
		if (temperature > owps_pkg::TEMP_MAX) begin
			t_cl = owps_pkg::TEMP_MAX;
		end else if (temperature < owps_pkg::TEMP_MIN) begin
			t_cl = owps_pkg::TEMP_MIN;
		end
		case (operation)
			owps_pkg::OP_SET_VOLT: begin
				set_lo     = voltage[7:0];
				set_hi     = {6'd0, voltage[9:8]};
				set_pos_lo = owps_pkg::POS_VOLT_LO;
				set_pos_hi = owps_pkg::POS_VOLT_HI;
			end
			owps_pkg::OP_SET_CURR: begin
				set_lo     = current_value[7:0];
				set_hi     = {{6{current_value[10]}}, current_value[9:8]};
				set_pos_lo = owps_pkg::POS_CURR_LO;
				set_pos_hi = owps_pkg::POS_CURR_HI;
			end
			default: begin
				set_lo     = t_cl[7:0] & 8'hF8;
				set_hi     = t_cl[15:8];
				set_pos_lo = owps_pkg::POS_TEMP_LO;
				set_pos_hi = owps_pkg::POS_TEMP_HI;
			end
		endcase
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = '0;
		unique case (state_q)
			S_INIT: begin
				we = 1'b1;
				wa = init_q;
				wd = (init_q == '0) ? owps_pkg::RESET_BYTE0 : 8'h00;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (operation) inside
						owps_pkg::OP_BUS_BYTE: begin
							if ((phase_q == P_WRITE_DATA) && wr_allowed) begin
								we = 1'b1;
								wa = {sel_q, count_q};
								wd = rx_byte;
							end
						end
						owps_pkg::OP_HOST_WRITE: begin
							we = addr_ok;
							wa = host_addr;
							wd = rx_byte;
						end
						owps_pkg::OP_HOST_READ: begin
							re = addr_ok;
							ra = host_addr;
						end
						owps_pkg::OP_SET_TEMP, owps_pkg::OP_SET_VOLT,
						owps_pkg::OP_SET_CURR: begin
							we = 1'b1;
							wa = set_pos_lo;
							wd = set_lo;
						end
						default: begin
						end
					endcase
				end
			end
			S_WR2: begin
				we = 1'b1;
				wa = wr2_addr_q;
				wd = wr2_data_q;
			end
			S_PREAD: begin
				re = !idx_q[3];
				ra = {sel_q, idx_q[2:0]};
			end
			S_CRC: begin
				if (step_q == 5'd0) begin
					re = 1'b1;
					ra = {crc_pg_q, 3'd0};
				end else if (crc_k[0] && (crc_byte != 3'd7)) begin
					re = 1'b1;
					ra = {crc_pg_q, 3'(crc_byte + 3'd1)};
				end
			end
			default: begin
			end
		endcase
	end

	// page memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_q <= mem[ra];
		end
	end

	// command sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			phase_q     <= P_IDLE;
			sel_q       <= '0;
			count_q     <= '0;
			init_q      <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			crc_acc_q   <= '0;
			crc_pg_q    <= '0;
			nxt_pend_q  <= 1'b0;
			nxt_pg_q    <= '0;
			wr2_addr_q  <= '0;
			wr2_data_q  <= '0;
			pend_q      <= 1'b0;
			pend_crc_q  <= 1'b0;
			pend_kind_q <= owps_pkg::KIND_BUS;
			pend_last_q <= 1'b0;
			strobe_q    <= 1'b0;
			out_byte_q  <= '0;
			out_kind_q  <= owps_pkg::KIND_BUS;
			last_q      <= 1'b0;
			for (int p = 0; p < owps_pkg::PAGES; p++) begin
				page_check_q[p] <= (p == 0) ? owps_pkg::RESET_CRC0 : 8'h00;
			end
		end else begin
			// tagged read data goes out as a result
			strobe_q <= pend_q;
			pend_q   <= 1'b0;
			if (pend_q) begin
				out_byte_q <= pend_crc_q ? page_check_q[sel_q] : rd_data_q;
				out_kind_q <= pend_kind_q;
				last_q     <= pend_last_q;
			end

			unique case (state_q)
				// clearing pass after reset
				S_INIT: begin
					init_q <= ADDR_W'(init_q + 1'b1);
					if (init_q == ADDR_W'(owps_pkg::MEM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (accept) begin
						unique case (operation) inside
							owps_pkg::OP_BUS_RESET: begin
								phase_q <= P_IDLE;
								count_q <= '0;
							end

							owps_pkg::OP_BUS_BYTE: begin
								unique case (phase_q)
									P_IDLE: begin
										if (!cmd_known) begin
											phase_q    <= P_DONE;
											strobe_q   <= 1'b1;
											out_byte_q <= rx_byte;
											out_kind_q <= owps_pkg::KIND_UNKNOWN;
											last_q     <= 1'b1;
										end else if (rx_byte == owps_pkg::CMD_READ_SP) begin
											phase_q <= P_READ_PAGE;
										end else if (rx_byte == owps_pkg::CMD_WRITE_SP) begin
											phase_q <= P_WRITE_PAGE;
										end else if ((rx_byte == owps_pkg::CMD_COPY_SP) ||
											(rx_byte == owps_pkg::CMD_RECALL)) begin
											phase_q <= P_RECALL;
										end else begin
											phase_q <= P_DONE;
										end
									end
									P_READ_PAGE: begin
										phase_q <= P_DONE;
										if (rx_pg_ok) begin
											sel_q   <= PAGE_W'(rx_byte);
											idx_q   <= '0;
											state_q <= S_PREAD;
										end
									end
									P_WRITE_PAGE: begin
										if (rx_pg_ok) begin
											sel_q   <= PAGE_W'(rx_byte);
											count_q <= '0;
											phase_q <= P_WRITE_DATA;
										end else begin
											phase_q <= P_DONE;
										end
									end
									P_WRITE_DATA: begin
										if (count_q == 3'd7) begin
											count_q    <= '0;
											phase_q    <= P_DONE;
											crc_pg_q   <= sel_q;
											nxt_pend_q <= 1'b0;
											step_q     <= '0;
											state_q    <= S_CRC;
										end else begin
											count_q <= 3'(count_q + 3'd1);
										end
									end
									P_RECALL: begin
										phase_q <= P_DONE;
									end
									default: begin
									end
								endcase
							end

							owps_pkg::OP_HOST_WRITE: begin
								if (addr_ok) begin
									crc_pg_q   <= host_pg;
									nxt_pend_q <= host_last && nxt_ok;
									nxt_pg_q   <= PAGE_W'(nxt8);
									step_q     <= '0;
									state_q    <= S_CRC;
								end else begin
									strobe_q   <= 1'b1;
									out_byte_q <= 8'h00;
									out_kind_q <= owps_pkg::KIND_RANGE;
									last_q     <= 1'b1;
								end
							end

							owps_pkg::OP_HOST_READ: begin
								if (addr_ok) begin
									pend_q      <= 1'b1;
									pend_crc_q  <= 1'b0;
									pend_kind_q <= owps_pkg::KIND_HOST;
									pend_last_q <= 1'b1;
								end else begin
									strobe_q   <= 1'b1;
									out_byte_q <= 8'h00;
									out_kind_q <= owps_pkg::KIND_RANGE;
									last_q     <= 1'b1;
								end
							end

							owps_pkg::OP_SET_TEMP, owps_pkg::OP_SET_VOLT,
							owps_pkg::OP_SET_CURR: begin
								wr2_addr_q <= set_pos_hi;
								wr2_data_q <= set_hi;
								crc_pg_q   <= '0;
								nxt_pend_q <= 1'b0;
								step_q     <= '0;
								state_q    <= S_WR2;
							end

							default: begin
							end
						endcase
					end
				end

				// second byte of a setter
				S_WR2: begin
					state_q <= S_CRC;
				end

				// eight page bytes, then the page crc
				S_PREAD: begin
					pend_q      <= 1'b1;
					pend_kind_q <= owps_pkg::KIND_BUS;
					pend_crc_q  <= idx_q[3];
					pend_last_q <= idx_q[3];
					idx_q       <= 4'(idx_q + 4'd1);
					if (idx_q[3]) begin
						state_q <= S_IDLE;
					end
				end

				// page crc, one nibble per cycle
				S_CRC: begin
					if (step_q == 5'd0) begin
						crc_acc_q <= 8'h00;
						step_q    <= 5'd1;
					end else begin
						crc_acc_q <= crc_nx;
						if (step_q == owps_pkg::CRC_STEPS) begin
							page_check_q[crc_pg_q] <= crc_nx;
							step_q                 <= '0;
							if (nxt_pend_q) begin
								nxt_pend_q <= 1'b0;
								crc_pg_q   <= nxt_pg_q;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							step_q <= 5'(step_q + 5'd1);
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
